// ===== hw/rtl/wkv_pkg.sv =====
// Shared types, constants and the hex-to-segment function for the key vote control unit.
`timescale 1ns / 1ps

package wkv_pkg;

   localparam int KeyCount = 3;

   localparam logic [7:0] WindowLengthReset   = 8'd100;
   localparam logic [7:0] PressThresholdReset = 8'd66;
   localparam logic [7:0] CountSaturate       = 8'hff;

   // Register indexes on the configuration port (taken from address bit 2).
   localparam logic RegWindowLength   = 1'b0;
   localparam logic RegPressThreshold = 1'b1;

   // Item kinds.
   localparam logic CmdTick    = 1'b0;
   localparam logic CmdReceive = 1'b1;

   // Key positions in the debounced flag vector.
   localparam int KeySend = 0;
   localparam int KeyDown = 1;
   localparam int KeyUp   = 2;

   typedef struct packed {
      logic       cmd;
      logic [2:0] levels;     // bit0 send, bit1 down, bit2 up; 0 = pressed
      logic [7:0] rx_byte;
   } req_item_type;

   typedef struct packed {
      logic       send_valid;
      logic [7:0] send_byte;
      logic [7:0] held_value;
      logic [6:0] seg_high;
      logic [6:0] seg_low;
      logic [2:0] keys_pressed;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0] window_length;
      logic [7:0] press_threshold;
   } cfg_type;

   // Segments a..g, bit0 = a.
   function automatic logic [6:0] hex_to_seg(input logic [3:0] nibble);
      logic [6:0] seg;
      unique case (nibble)
         4'h0: seg = 7'h3f;
         4'h1: seg = 7'h06;
         4'h2: seg = 7'h5b;
         4'h3: seg = 7'h4f;
         4'h4: seg = 7'h66;
         4'h5: seg = 7'h6d;
         4'h6: seg = 7'h7d;
         4'h7: seg = 7'h07;
         4'h8: seg = 7'h7f;
         4'h9: seg = 7'h6f;
         4'ha: seg = 7'h77;
         4'hb: seg = 7'h7c;
         4'hc: seg = 7'h39;
         4'hd: seg = 7'h5e;
         4'he: seg = 7'h79;
         4'hf: seg = 7'h71;
      endcase
      return seg;
   endfunction

endpackage

// ===== hw/rtl/wkv_csr.sv =====
// APB-style configuration registers for window length and press threshold.
`timescale 1ns / 1ps

module wkv_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output wkv_pkg::cfg_type   cfg
);

   logic [7:0] window_length_ff;
   logic [7:0] press_threshold_ff;
   logic       write_en;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff   <= wkv_pkg::WindowLengthReset;
         press_threshold_ff <= wkv_pkg::PressThresholdReset;
      end else if (write_en) begin
         unique case (paddr[2])
            wkv_pkg::RegWindowLength:   window_length_ff   <= pwdata[7:0];
            wkv_pkg::RegPressThreshold: press_threshold_ff <= pwdata[7:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         wkv_pkg::RegWindowLength:   prdata = {24'd0, window_length_ff};
         wkv_pkg::RegPressThreshold: prdata = {24'd0, press_threshold_ff};
      endcase
   end

   assign cfg.window_length   = window_length_ff;
   assign cfg.press_threshold = press_threshold_ff;

endmodule

// ===== hw/rtl/wkv_core.sv =====
// Vote counters, debounced key flags and the held byte, with the per-transaction result logic.
`timescale 1ns / 1ps

module wkv_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  wkv_pkg::req_item_type   item,
   input  wkv_pkg::cfg_type        cfg,
   output wkv_pkg::rsp_item_type   result
);

   logic [7:0] tick_count_ff, tick_count_in;
   logic [7:0] low_count_ff [wkv_pkg::KeyCount];
   logic [7:0] low_count_in [wkv_pkg::KeyCount];
   logic [7:0] counted      [wkv_pkg::KeyCount];
   logic [2:0] flags_ff, flags_in;
   logic [7:0] value_ff, value_in;
   logic [8:0] ticks;
   logic       window_end;
   logic [2:0] rising;
   logic [2:0] vote;
   logic       send_valid;

   always_comb begin
      for (int i = 0; i < wkv_pkg::KeyCount; i++) begin
         if (!item.levels[i] && low_count_ff[i] != wkv_pkg::CountSaturate)
            counted[i] = low_count_ff[i] + 8'd1;
         else
            counted[i] = low_count_ff[i];
         vote[i] = counted[i] > cfg.press_threshold;
      end
      ticks      = {1'b0, tick_count_ff} + 9'd1;
      window_end = ticks >= {1'b0, cfg.window_length};
      rising     = vote & ~flags_ff;

      tick_count_in = tick_count_ff;
      flags_in      = flags_ff;
      value_in      = value_ff;
      send_valid    = 1'b0;
      for (int i = 0; i < wkv_pkg::KeyCount; i++) low_count_in[i] = low_count_ff[i];

      if (item.cmd == wkv_pkg::CmdReceive) begin
         value_in = item.rx_byte;
      end else if (window_end) begin
         send_valid    = rising[wkv_pkg::KeySend];
         value_in      = value_ff - {7'd0, rising[wkv_pkg::KeyDown]}
                                  + {7'd0, rising[wkv_pkg::KeyUp]};
         flags_in      = vote;
         tick_count_in = 8'd0;
         for (int i = 0; i < wkv_pkg::KeyCount; i++) low_count_in[i] = 8'd0;
      end else begin
         tick_count_in = ticks[7:0];
         for (int i = 0; i < wkv_pkg::KeyCount; i++) low_count_in[i] = counted[i];
      end

      result.send_valid   = send_valid;
      result.send_byte    = send_valid ? value_ff : 8'd0;
      result.held_value   = value_in;
      result.seg_high     = wkv_pkg::hex_to_seg(value_in[7:4]);
      result.seg_low      = wkv_pkg::hex_to_seg(value_in[3:0]);
      result.keys_pressed = flags_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= 8'd0;
         flags_ff      <= 3'd0;
         value_ff      <= 8'd0;
         for (int i = 0; i < wkv_pkg::KeyCount; i++) low_count_ff[i] <= 8'd0;
      end else if (advance) begin
         tick_count_ff <= tick_count_in;
         flags_ff      <= flags_in;
         value_ff      <= value_in;
         for (int i = 0; i < wkv_pkg::KeyCount; i++) low_count_ff[i] <= low_count_in[i];
      end
   end

endmodule

// ===== hw/rtl/windowed_key_vote_value_control_unit.sv =====
// Top level of the windowed key vote control unit: input register, core, result register, CSRs.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  cmd, three key levels, rx_byte
// rsp       out        rsp_valid / rsp_ready  send flag and byte, held byte, segments, keys
// csr       in/out     psel, penable, pready  paddr, pwdata, prdata (two 8-bit registers)
//
// An accepted transaction waits in the input register and moves into the result register
// through the vote/value logic once the result register is empty or being drained. Its result
// is valid from that point until it is taken at an edge with rsp_ready high.
// One transaction is accepted per cycle while the result side keeps up. Synchronous reset
// clears the counters, flags, held byte and both valid bits and restores the register
// defaults. When rsp_ready is low the result register holds, the input register still
// takes one more transaction, and req_ready drops only when both are full.

module windowed_key_vote_value_control_unit (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic        req_key_send_level,
   input  logic        req_key_down_level,
   input  logic        req_key_up_level,
   input  logic [7:0]  req_rx_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_send_valid,
   output logic [7:0]  rsp_send_byte,
   output logic [7:0]  rsp_held_value,
   output logic [6:0]  rsp_seg_high,
   output logic [6:0]  rsp_seg_low,
   output logic [2:0]  rsp_keys_pressed,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   wkv_pkg::cfg_type        cfg;
   wkv_pkg::req_item_type   in_item_ff, in_item_in;
   wkv_pkg::rsp_item_type   out_item_ff, core_result;
   logic                    in_valid_ff, in_valid_in;
   logic                    out_valid_ff, out_valid_in;
   logic                    advance;
   logic                    req_fire;

   wkv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The held transaction moves on whenever the result register is empty or being drained.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign in_item_in.cmd     = req_cmd;
   assign in_item_in.levels  = {req_key_up_level, req_key_down_level, req_key_send_level};
   assign in_item_in.rx_byte = req_rx_byte;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   // The core commits its state only on the cycle the transaction moves into the result stage.
   wkv_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) in_item_ff  <= in_item_in;
      if (advance)  out_item_ff <= core_result;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_send_valid   = out_item_ff.send_valid;
   assign rsp_send_byte    = out_item_ff.send_byte;
   assign rsp_held_value   = out_item_ff.held_value;
   assign rsp_seg_high     = out_item_ff.seg_high;
   assign rsp_seg_low      = out_item_ff.seg_low;
   assign rsp_keys_pressed = out_item_ff.keys_pressed;

endmodule

// ===== tb/sv/tb_windowed_key_vote_value_control_unit.sv =====
// Self-checking testbench for the windowed key vote control unit: directed rows, then random phases.
`timescale 1ns / 1ps

module tb_windowed_key_vote_value_control_unit;

   // Byte addresses of the two configuration registers.
   localparam logic [2:0] AddrWindowLength   = 3'd0;
   localparam logic [2:0] AddrPressThreshold = 3'd4;

   // Kinds of row in the directed stimulus list: a transaction, or a register write.
   typedef enum logic [1:0] {
      RowItem,
      RowSetWindow,
      RowSetThreshold
   } row_kind_type;

   // How the two sides of the block idle during a phase.
   typedef enum logic [1:0] {
      IdleNone,
      IdleSender,
      IdleReceiver,
      IdleBoth
   } idle_mode_type;

   typedef struct {
      row_kind_type          kind;
      wkv_pkg::req_item_type item;   // rx_byte doubles as the write data of a register row
      logic                  typed;  // 1: the expected result below is checked as typed
      wkv_pkg::rsp_item_type result;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = wkv_pkg::CmdTick;
   logic        req_key_send_level = 1'b1;
   logic        req_key_down_level = 1'b1;
   logic        req_key_up_level = 1'b1;
   logic [7:0]  req_rx_byte = 8'h00;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_send_valid;
   logic [7:0]  rsp_send_byte;
   logic [7:0]  rsp_held_value;
   logic [6:0]  rsp_seg_high;
   logic [6:0]  rsp_seg_low;
   logic [2:0]  rsp_keys_pressed;

   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   windowed_key_vote_value_control_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_key_send_level (req_key_send_level),
      .req_key_down_level (req_key_down_level),
      .req_key_up_level (req_key_up_level),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_send_valid   (rsp_send_valid),
      .rsp_send_byte    (rsp_send_byte),
      .rsp_held_value   (rsp_held_value),
      .rsp_seg_high     (rsp_seg_high),
      .rsp_seg_low      (rsp_seg_low),
      .rsp_keys_pressed (rsp_keys_pressed),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // 10 ns clock period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the block's state and configuration, advanced once per accepted
   // transaction. The vote logic below mirrors the block's documented behavior.
   logic [7:0]   cfg_window    = wkv_pkg::WindowLengthReset;
   logic [7:0]   cfg_threshold = wkv_pkg::PressThresholdReset;
   logic [7:0]   vote_ticks    = 8'd0;
   logic [7:0]   vote_lows [wkv_pkg::KeyCount];
   logic [2:0]   debounced     = 3'b000;
   logic [7:0]   held_byte     = 8'h00;

   wkv_pkg::rsp_item_type pending_results [$];     // expected results, oldest first
   stim_row_type          directed_rows [$];
   idle_mode_type         idle_mode = IdleNone;

   int failures     = 0;
   int accepted     = 0;
   int results_seen = 0;
   int transmits    = 0;

   initial begin
      for (int k = 0; k < wkv_pkg::KeyCount; k++) vote_lows[k] = 8'd0;
   end

   // Seven-segment pattern of one hex digit, segment a in bit 0.
   function automatic logic [6:0] digit_segments(input logic [3:0] digit);
      logic [6:0] seg;
      case (digit)
         4'h0: seg = 7'h3f;
         4'h1: seg = 7'h06;
         4'h2: seg = 7'h5b;
         4'h3: seg = 7'h4f;
         4'h4: seg = 7'h66;
         4'h5: seg = 7'h6d;
         4'h6: seg = 7'h7d;
         4'h7: seg = 7'h07;
         4'h8: seg = 7'h7f;
         4'h9: seg = 7'h6f;
         4'ha: seg = 7'h77;
         4'hb: seg = 7'h7c;
         4'hc: seg = 7'h39;
         4'hd: seg = 7'h5e;
         4'he: seg = 7'h79;
         default: seg = 7'h71;
      endcase
      return seg;
   endfunction

   // Applies one transaction to the shadow state and returns the result it causes.
   function automatic wkv_pkg::rsp_item_type vote_and_update(input wkv_pkg::req_item_type it);
      wkv_pkg::rsp_item_type r;
      logic [2:0]   voted;
      logic [2:0]   newly_pressed;
      logic [7:0]   prior_value;
      r = '0;
      if (it.cmd == wkv_pkg::CmdReceive) begin
         // A received byte replaces the held value; keys and ticks are left alone.
         held_byte = it.rx_byte;
      end else begin
         for (int k = 0; k < wkv_pkg::KeyCount; k++)
            if (!it.levels[k] && vote_lows[k] != wkv_pkg::CountSaturate)
               vote_lows[k] = vote_lows[k] + 8'd1;
         // The window closes once the tick count reaches or passes the length, so a
         // zero length behaves like one and a shortened window closes on the next tick.
         if ({1'b0, vote_ticks} + 9'd1 >= {1'b0, cfg_window}) begin
            voted = 3'b000;
            for (int k = 0; k < wkv_pkg::KeyCount; k++)
               if (vote_lows[k] > cfg_threshold) voted[k] = 1'b1;
            newly_pressed = voted & ~debounced;
            prior_value = held_byte;
            if (newly_pressed[wkv_pkg::KeySend]) begin
               r.send_valid = 1'b1;
               r.send_byte  = prior_value;
            end
            // Down and up edges in the same window cancel out.
            if (newly_pressed[wkv_pkg::KeyDown]) held_byte = held_byte - 8'd1;
            if (newly_pressed[wkv_pkg::KeyUp])   held_byte = held_byte + 8'd1;
            debounced  = voted;
            vote_ticks = 8'd0;
            for (int k = 0; k < wkv_pkg::KeyCount; k++) vote_lows[k] = 8'd0;
         end else begin
            vote_ticks = vote_ticks + 8'd1;
         end
      end
      r.held_value   = held_byte;
      r.seg_high     = digit_segments(held_byte[7:4]);
      r.seg_low      = digit_segments(held_byte[3:0]);
      r.keys_pressed = debounced;
      return r;
   endfunction

   function automatic void add_row(input row_kind_type kind, input logic cmd,
                                   input logic [2:0] levels, input logic [7:0] data,
                                   input logic typed, input logic sv, input logic [7:0] sb,
                                   input logic [7:0] held, input logic [6:0] sh,
                                   input logic [6:0] sl, input logic [2:0] keys);
      stim_row_type row;
      row.kind   = kind;
      row.item   = '{cmd: cmd, levels: levels, rx_byte: data};
      row.typed  = typed;
      row.result = '{send_valid: sv, send_byte: sb, held_value: held,
                     seg_high: sh, seg_low: sl, keys_pressed: keys};
      directed_rows.push_back(row);
   endfunction

   function automatic bit sender_pauses();
      case (idle_mode)
         IdleSender: return $urandom_range(0, 99) < 58;
         IdleBoth:   return $urandom_range(0, 99) < 31;
         default:    return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (idle_mode)
         IdleReceiver: return $urandom_range(0, 99) < 58;
         IdleBoth:     return $urandom_range(0, 99) < 31;
         default:      return 1'b0;
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [7:0] exp_val,
                                       input logic [7:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
         failures++;
      end
   endfunction

   // Offers one transaction and holds it until it is accepted. Valid is only ever
   // lowered by an idle gap or a drain, so back-to-back transactions keep it high without a
   // second assignment in the same time step. The expectation is queued at the
   // edge of acceptance; a typed expectation replaces the predicted one but the
   // shadow state is advanced either way.
   task automatic send_item(input wkv_pkg::req_item_type it, input logic typed,
                            input wkv_pkg::rsp_item_type typed_result);
      wkv_pkg::rsp_item_type predicted;
      while (sender_pauses()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_cmd            <= it.cmd;
      req_key_send_level <= it.levels[wkv_pkg::KeySend];
      req_key_down_level <= it.levels[wkv_pkg::KeyDown];
      req_key_up_level   <= it.levels[wkv_pkg::KeyUp];
      req_rx_byte        <= it.rx_byte;
      do @(posedge clock); while (!req_ready);
      predicted = vote_and_update(it);
      pending_results.push_back(typed ? typed_result : predicted);
      accepted++;
   endtask

   // Stops offering transactions and waits until every expected result has been
   // taken, then lets the two-stage pipeline settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register takes the data at the edge that
   // ends the access cycle.
   task automatic csr_write(input logic [2:0] addr, input logic [7:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= {24'd0, data};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == AddrWindowLength) cfg_window = data;
      else cfg_threshold = data;
   endtask

   // The receiver drops ready at random according to the current idle mode.
   always @(posedge clock) begin
      rsp_ready <= !receiver_stalls();
   end

   // Every result transaction is compared field by field with the oldest expectation.
   always @(posedge clock) begin : result_check
      wkv_pkg::rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_send_valid === 1'b1) transmits++;
         if (pending_results.size() == 0) begin
            $display("%0t ns: result transaction with no expectation, held_value %0h",
                     $time, rsp_held_value);
            failures++;
         end else begin
            want = pending_results.pop_front();
            check_field("send_valid",   {7'd0, want.send_valid},   {7'd0, rsp_send_valid});
            check_field("send_byte",    want.send_byte,            rsp_send_byte);
            check_field("held_value",   want.held_value,           rsp_held_value);
            check_field("seg_high",     {1'b0, want.seg_high},     {1'b0, rsp_seg_high});
            check_field("seg_low",      {1'b0, want.seg_low},      {1'b0, rsp_seg_low});
            check_field("keys_pressed", {5'd0, want.keys_pressed}, {5'd0, rsp_keys_pressed});
         end
      end
   end

   initial begin : stimulus
      wkv_pkg::req_item_type it;
      wkv_pkg::rsp_item_type none;
      logic [2:0]    intent;
      int            roll;
      int            phase_window [6];
      int            phase_items [6];
      idle_mode_type phase_idle [6];

      none   = '0;
      intent = 3'b000;
      phase_window = '{4, 1, 6, 3, 255, 2};
      phase_items  = '{80, 80, 80, 80, 70, 70};
      phase_idle   = '{IdleNone, IdleSender, IdleReceiver, IdleBoth, IdleNone, IdleBoth};

      // Directed rows. The first three run at the reset settings (window of 100), so
      // the two ticks only count. Shortening the window to one then closes it on the
      // next tick. Later rows walk the held byte through both wrap points, cancel a
      // down and an up edge, check that a received byte keeps the key states, and run
      // a zero window length with the threshold at its top and at its bottom.
      add_row(RowItem, wkv_pkg::CmdReceive, 3'b111, 8'ha5, 1, 0, 8'h00, 8'ha5, 7'h77, 7'h6d,
              3'b000);
      add_row(RowItem, wkv_pkg::CmdTick,    3'b110, 8'h00, 1, 0, 8'h00, 8'ha5, 7'h77, 7'h6d,
              3'b000);
      add_row(RowItem, wkv_pkg::CmdTick,    3'b111, 8'h00, 1, 0, 8'h00, 8'ha5, 7'h77, 7'h6d,
              3'b000);
      add_row(RowSetWindow,    wkv_pkg::CmdTick, 3'b111, 8'd1, 0, 0, 0, 0, 0, 0, 0);
      add_row(RowSetThreshold, wkv_pkg::CmdTick, 3'b111, 8'd0, 0, 0, 0, 0, 0, 0, 0);
      add_row(RowItem, wkv_pkg::CmdTick,    3'b110, 8'h00, 1, 1, 8'ha5, 8'ha5, 7'h77, 7'h6d,
              3'b001);
      add_row(RowItem, wkv_pkg::CmdTick,    3'b110, 8'h00, 1, 0, 8'h00, 8'ha5, 7'h77, 7'h6d,
              3'b001);
      add_row(RowItem, wkv_pkg::CmdTick,    3'b101, 8'h00, 1, 0, 8'h00, 8'ha4, 7'h77, 7'h66,
              3'b010);
      add_row(RowItem, wkv_pkg::CmdTick,    3'b111, 8'h00, 1, 0, 8'h00, 8'ha4, 7'h77, 7'h66,
              3'b000);
      add_row(RowItem, wkv_pkg::CmdTick,    3'b011, 8'h00, 1, 0, 8'h00, 8'ha5, 7'h77, 7'h6d,
              3'b100);
      add_row(RowItem, wkv_pkg::CmdTick,    3'b000, 8'h00, 1, 1, 8'ha5, 8'ha4, 7'h77, 7'h66,
              3'b111);
      add_row(RowItem, wkv_pkg::CmdTick,    3'b111, 8'h00, 1, 0, 8'h00, 8'ha4, 7'h77, 7'h66,
              3'b000);
      add_row(RowItem, wkv_pkg::CmdTick,    3'b001, 8'h00, 1, 0, 8'h00, 8'ha4, 7'h77, 7'h66,
              3'b110);
      add_row(RowItem, wkv_pkg::CmdReceive, 3'b111, 8'h00, 1, 0, 8'h00, 8'h00, 7'h3f, 7'h3f,
              3'b110);
      add_row(RowItem, wkv_pkg::CmdTick,    3'b111, 8'h00, 1, 0, 8'h00, 8'h00, 7'h3f, 7'h3f,
              3'b000);
      add_row(RowItem, wkv_pkg::CmdTick,    3'b101, 8'h00, 1, 0, 8'h00, 8'hff, 7'h71, 7'h71,
              3'b010);
      add_row(RowItem, wkv_pkg::CmdReceive, 3'b111, 8'hff, 1, 0, 8'h00, 8'hff, 7'h71, 7'h71,
              3'b010);
      add_row(RowItem, wkv_pkg::CmdTick,    3'b111, 8'h00, 1, 0, 8'h00, 8'hff, 7'h71, 7'h71,
              3'b000);
      add_row(RowItem, wkv_pkg::CmdTick,    3'b011, 8'h00, 1, 0, 8'h00, 8'h00, 7'h3f, 7'h3f,
              3'b100);
      add_row(RowSetWindow,    wkv_pkg::CmdTick, 3'b111, 8'd0,   0, 0, 0, 0, 0, 0, 0);
      add_row(RowSetThreshold, wkv_pkg::CmdTick, 3'b111, 8'd255, 0, 0, 0, 0, 0, 0, 0);
      add_row(RowItem, wkv_pkg::CmdTick,    3'b000, 8'h00, 1, 0, 8'h00, 8'h00, 7'h3f, 7'h3f,
              3'b000);
      add_row(RowItem, wkv_pkg::CmdReceive, 3'b111, 8'h5a, 0, 0, 0, 0, 0, 0, 0);
      add_row(RowSetThreshold, wkv_pkg::CmdTick, 3'b111, 8'd0, 0, 0, 0, 0, 0, 0, 0);
      add_row(RowItem, wkv_pkg::CmdTick,    3'b000, 8'h00, 0, 0, 0, 0, 0, 0, 0);

      // Synchronous reset applied once, at the start.
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            RowSetWindow: begin
               drain_results();
               csr_write(AddrWindowLength, directed_rows[i].item.rx_byte);
            end
            RowSetThreshold: begin
               drain_results();
               csr_write(AddrPressThreshold, directed_rows[i].item.rx_byte);
            end
            default: begin
               send_item(directed_rows[i].item, directed_rows[i].typed,
                         directed_rows[i].result);
            end
         endcase
      end

      // Random phases. Most ticks follow a key pattern chosen at the start of each
      // window, with a little bounce on every sample, so that votes actually pass the
      // threshold and produce press edges. Some ticks are pure noise and about one in
      // ten transactions loads a random byte. The last phase starts by cutting a long
      // window that is already well under way down to two ticks.
      for (int p = 0; p < 6; p++) begin
         drain_results();
         idle_mode = phase_idle[p];
         csr_write(AddrWindowLength, phase_window[p][7:0]);
         case (p)
            0: csr_write(AddrPressThreshold, 8'd2);
            2: csr_write(AddrPressThreshold, 8'($urandom_range(0, 6)));
            3: csr_write(AddrPressThreshold, 8'd1);
            5: csr_write(AddrPressThreshold, 8'd1);
            default: csr_write(AddrPressThreshold, 8'd0);
         endcase
         for (int n = 0; n < phase_items[p]; n++) begin
            // Once in the run the sender waits for the block to empty completely.
            if (p == 2 && n == 40) drain_results();
            if (vote_ticks == 8'd0) intent = 3'($urandom_range(0, 7));
            roll = $urandom_range(0, 99);
            it.cmd     = wkv_pkg::CmdTick;
            it.rx_byte = 8'($urandom_range(0, 255));
            if (roll < 10) begin
               it.cmd    = wkv_pkg::CmdReceive;
               it.levels = 3'($urandom_range(0, 7));
            end else if (roll < 22) begin
               it.levels = 3'($urandom_range(0, 7));
            end else begin
               for (int k = 0; k < wkv_pkg::KeyCount; k++)
                  it.levels[k] = intent[k] ? ($urandom_range(0, 9) < 2)
                                           : ($urandom_range(0, 9) != 0);
            end
            send_item(it, 1'b0, none);
         end
      end

      idle_mode = IdleNone;
      drain_results();
      repeat (10) @(posedge clock);

      $display("Sent %0d transactions: directed rows, then six random phases with windows",
               accepted);
      $display("from 1 to 255 and all idle modes; %0d results checked, %0d transmits seen.",
               results_seen, transmits);
      if (failures == 0 && pending_results.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== windowed_key_vote_value_control_unit.f =====
hw/rtl/wkv_pkg.sv
hw/rtl/wkv_csr.sv
hw/rtl/wkv_core.sv
hw/rtl/windowed_key_vote_value_control_unit.sv
tb/sv/tb_windowed_key_vote_value_control_unit.sv
